[hw/rtl/sha_pkg.sv]
package sha_pkg;

    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueueIdxW  = $clog2(QueueDepth);
    localparam int unsigned OutDepth   = 8;

    // One request as it travels from the front to the back.
    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } t_req;

    // Digest word as handed to the output queue.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_res;

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

[hw/rtl/sha256_byte_stream_hasher.sv]
// SHA-256 over a byte stream. Bytes are buffered one by one; each full
// 64-byte block then goes through the single round unit (load, 64
// rounds, add). A message end adds byte-wise padding and one or two
// block compressions, then the eight digest words are written, which
// appear in order, word 0 first. Bytes of the next message keep
// flowing while a digest waits to be popped; only the writing of the
// next digest waits for it to drain, and requests queue in a four-entry
// queue meanwhile.
module sha256_byte_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    sha_pkg::t_req w_req;
    sha_pkg::t_res w_res;
    logic          w_avail, w_take;

    sha_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_msg_byte, .i_byte_valid, .i_end_of_message,
        .o_full(full), .o_req_avail(w_avail), .o_req(w_req), .i_req_take(w_take));

    sha_core u_core (
        .i_clk, .i_rst_n, .i_req_avail(w_avail), .i_req(w_req), .o_req_take(w_take),
        .o_empty(empty), .o_res(w_res), .i_pop(pop));

    assign o_digest_word = w_res.word;
    assign o_word_index  = w_res.index;
    assign o_last_word   = w_res.last;
endmodule

[hw/rtl/sha_front.sv]
// Accepts requests, drops those with neither flag set, and queues the rest.
module sha_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_msg_byte,
    input  logic          i_byte_valid,
    input  logic          i_end_of_message,
    output logic          o_full,
    output logic          o_req_avail,
    output sha_pkg::t_req o_req,
    input  logic          i_req_take
);
    sha_pkg::t_req                  r_q [sha_pkg::QueueDepth];
    logic [sha_pkg::QueueIdxW-1:0]  r_wp, r_rp;
    logic [sha_pkg::QueueIdxW:0]    r_cnt;
    logic                           w_in, w_keep, w_out;

    assign o_full      = (r_cnt == (sha_pkg::QueueIdxW+1)'(sha_pkg::QueueDepth));
    assign w_in        = i_push && !o_full;
    assign w_keep      = w_in && (i_byte_valid || i_end_of_message);
    assign o_req_avail = (r_cnt != '0);
    assign w_out       = i_req_take && o_req_avail;
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_keep) begin
            r_q[r_wp] <= '{data: i_msg_byte, valid: i_byte_valid, last: i_end_of_message};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_keep) r_wp <= r_wp + 1'b1;
            if (w_out)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (sha_pkg::QueueIdxW+1)'(w_keep) - (sha_pkg::QueueIdxW+1)'(w_out);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (sha_pkg::QueueIdxW+1)'(sha_pkg::QueueDepth))
        else $error("front queue overflow");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !w_out) else $error("front queue popped while empty");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> (r_cnt != '0)) else $error("full queue lost entries");
endmodule

[hw/rtl/sha_core.sv]
// Buffers bytes, pads, runs 64 rounds per block on one round unit and
// queues the eight digest words.
module sha_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_avail,
    input  sha_pkg::t_req i_req,
    output logic          o_req_take,
    output logic          o_empty,
    output sha_pkg::t_res o_res,
    input  logic          i_pop
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_ROUND = 6'b000100,
        S_ADD   = 6'b001000,
        S_EMIT  = 6'b010000,
        S_LEN   = 6'b100000
    } t_state;

    t_state       r_state;
    logic [31:0]  r_blk [16];
    logic [63:0]  r_cnt;
    logic [31:0]  r_h [8];
    logic [31:0]  r_v [8];
    logic [31:0]  r_w [16];
    logic [5:0]   r_rnd;
    logic [5:0]   r_pos;
    logic         r_final;
    logic         r_second;
    logic         r_marked;
    logic         r_len_in;
    logic [3:0]   r_emit;
    sha_pkg::t_res r_oq [sha_pkg::OutDepth];
    logic [2:0]   r_orp;
    logic [3:0]   r_ocnt;

    logic [31:0] w_wt, w_wnew, w_t1, w_t2, w_s0, w_s1;
    logic        w_take, w_pop, w_len_due;

    assign o_empty = (r_ocnt == 4'd0);
    assign w_pop   = i_pop && !o_empty;
    assign o_res   = r_oq[r_orp];
    assign w_take  = (r_state == S_IDLE) && i_req_avail;
    assign o_req_take = w_take;

    // The length goes in once the end marker is placed and eight bytes remain.
    assign w_len_due = r_final && r_marked && (r_second || r_cnt[5:0] < 6'd56);

    // Message schedule kept as a sliding window of sixteen words.
    assign w_s0   = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
    assign w_s1   = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
    assign w_wnew = w_s1 + r_w[9] + w_s0 + r_w[0];
    assign w_wt   = r_w[0];
    assign w_t1 = r_v[7] + (sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11)
                  ^ sha_pkg::rotr(r_v[4], 25)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                  + sha_pkg::RoundK[r_rnd] + w_wt;
    assign w_t2 = (sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13)
                  ^ sha_pkg::rotr(r_v[0], 22))
                  + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ocnt  <= '0;
            r_orp   <= '0;
            r_final <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::InitH[i];
        end else begin
            if (w_pop) begin
                r_orp  <= r_orp + 1'b1;
                r_ocnt <= r_ocnt - 4'd1;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_final  <= i_req.last;
                        r_second <= 1'b0;
                        r_marked <= 1'b0;
                        r_len_in <= 1'b0;
                        if (i_req.valid) begin
                            r_blk[r_cnt[5:2]][{~r_cnt[1:0], 3'b000} +: 8] <= i_req.data;
                            r_cnt <= r_cnt + 64'd1;
                            if (r_cnt[5:0] == 6'd63) begin
                                r_state <= S_LEN;
                            end else if (i_req.last) begin
                                r_pos   <= r_cnt[5:0] + 6'd1;
                                r_state <= S_PAD;
                            end
                        end else begin
                            r_pos   <= r_cnt[5:0];
                            r_state <= S_PAD;
                        end
                    end
                end
                // One byte of padding per cycle from the fill position up.
                S_PAD: begin
                    if (!r_marked && (r_pos == r_cnt[5:0])) begin
                        r_blk[r_pos[5:2]][{~r_pos[1:0], 3'b000} +: 8] <= 8'h80;
                        r_marked <= 1'b1;
                    end else begin
                        r_blk[r_pos[5:2]][{~r_pos[1:0], 3'b000} +: 8] <= 8'h00;
                    end
                    r_pos <= r_pos + 6'd1;
                    if (r_pos == 6'd63) begin
                        r_state <= S_LEN;
                    end
                end
                // Load the window and working words; write the length when due.
                S_LEN: begin
                    for (int i = 0; i < 14; i++) r_w[i] <= r_blk[i];
                    r_w[14]  <= w_len_due ? r_cnt[60:29] : r_blk[14];
                    r_w[15]  <= w_len_due ? {r_cnt[28:0], 3'b000} : r_blk[15];
                    r_len_in <= w_len_due;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_rnd   <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + w_t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= w_t1 + w_t2;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                    r_w[15] <= w_wnew;
                    r_rnd <= r_rnd + 6'd1;
                    if (r_rnd == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    if (!r_final) begin
                        r_state <= S_IDLE;
                    end else if (!r_len_in) begin
                        // Length did not fit: another block of padding plus length.
                        r_second <= 1'b1;
                        r_pos    <= 6'd0;
                        r_state  <= S_PAD;
                    end else begin
                        r_emit  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                // Words are written only once the previous digest has been popped.
                S_EMIT: begin
                    if (o_empty) begin
                        if (r_emit == 4'd8) begin
                            r_ocnt  <= 4'd8;
                            r_orp   <= '0;
                            r_cnt   <= '0;
                            r_final <= 1'b0;
                            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::InitH[i];
                            r_state <= S_IDLE;
                        end else begin
                            r_oq[r_emit[2:0]] <= '{word: r_h[r_emit[2:0]],
                                                  index: r_emit[2:0],
                                                  last: (r_emit == 4'd7)};
                            r_emit <= r_emit + 4'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_emit_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && (r_emit != 4'd0)) |-> o_empty)
        else $error("digest written while previous digest pending");
    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 4'd8) else $error("output count out of range");
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_res.last == (o_res.index == 3'd7)))
        else $error("last flag disagrees with word index");
endmodule
